>>> design/calendar_day_number_converter_core_defines.svh
// ----------------------------------------------------------------------------
// Calendar day number converter: assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DAY_NUMBER_CONVERTER_CORE_DEFINES_SVH
`define CALENDAR_DAY_NUMBER_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDNC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CDNC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cdnc_pkg.sv
// ----------------------------------------------------------------------------
// Calendar day number converter package
// Payload types, control structs, calendar constants and small helpers.
// ----------------------------------------------------------------------------
package cdnc_pkg;

  localparam int unsigned DAYNUM_IN_W  = 17;
  localparam int unsigned DAYNUM_OUT_W = 16;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned MONTH_W      = 4;
  localparam int unsigned DAY_W        = 5;
  localparam int unsigned WDAY_W       = 3;
  localparam int unsigned YCNT_W       = 9;
  localparam int unsigned ACC_W        = 17;
  localparam int unsigned OPD_W        = 9;

  localparam logic [BYTE_W-1:0]  YEAR_LAST      = 8'd99;
  localparam logic [BYTE_W-1:0]  MONTH_LAST_IN  = 8'd12;
  localparam logic [MONTH_W-1:0] MONTH_LAST     = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FIRST    = 4'd1;
  localparam logic [WDAY_W-1:0]  WDAY_DAY0      = 3'd6;
  localparam logic [WDAY_W-1:0]  WDAY_SUNDAY    = 3'd7;
  localparam logic [OPD_W-1:0]   LEN_YEAR       = 9'd365;
  localparam logic [OPD_W-1:0]   LEN_LEAP_YEAR  = 9'd366;
  localparam logic [6:0]         CENT_LAST      = 7'd99;
  localparam logic [8:0]         QUAD_CENT_LAST = 9'd399;

  typedef enum logic {
    OP_TO_DATE   = 1'b0,
    OP_TO_DAYNUM = 1'b1
  } cdnc_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_FINISH
  } cdnc_state_t;

  typedef enum logic [1:0] {
    OPD_YEAR,
    OPD_MONTH,
    OPD_DAY
  } cdnc_opd_sel_t;

  typedef struct packed {
    cdnc_op_t                operation;
    logic [DAYNUM_IN_W-1:0]  day_number_in;
    logic [BYTE_W-1:0]       year_in;
    logic [BYTE_W-1:0]       month_in;
    logic [BYTE_W-1:0]       day_in;
  } cdnc_in_t;

  typedef struct packed {
    logic [DAYNUM_OUT_W-1:0] day_number_out;
    logic                    invalid;
    logic [BYTE_W-1:0]       year_out;
    logic [MONTH_W-1:0]      month_out;
    logic [DAY_W-1:0]        day_out;
    logic [WDAY_W-1:0]       weekday_out;
  } cdnc_out_t;

  typedef struct packed {
    logic          load;
    logic          acc_en;
    cdnc_opd_sel_t sel;
    logic          yr_inc;
    logic          mon_inc;
    logic          bad_set;
    logic          out_load;
  } cdnc_ctrl_t;

  typedef struct packed {
    cdnc_op_t op;
    logic     less;
    logic     year_hit;
    logic     mon_hit;
    logic     mon_last;
    logic     bad;
  } cdnc_stat_t;

  // Days in month m (1..12); leap selects the long February.
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    case (m)
      4'd2:                    return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  // Remainder by seven of a value below 49.
  function automatic logic [WDAY_W-1:0] mod7_small(input logic [5:0] x);
    logic [5:0] v;
    v = x;
    if (v >= 6'd28) v = v - 6'd28;
    if (v >= 6'd14) v = v - 6'd14;
    if (v >= 6'd7)  v = v - 6'd7;
    return v[WDAY_W-1:0];
  endfunction

endpackage

>>> design/calendar_day_number_converter_core.sv
// One beat at a time; the year/month walk on the shared unit holds off the next.
// A finished result waits in the output register while the next beat is taken.
// Reset: synchronous, active low; clears sequencer state and output valid only.
// ----------------------------------------------------------------------------
// Calendar day number converter core
// Converts between day numbers (day 0 = 1 Jan 2000) and Gregorian dates.
// ----------------------------------------------------------------------------
//
// Operation "to date": the day number is loaded into the accumulator and the
// shared unit subtracts whole years (365/366) until the remainder fits in the
// current year, then whole months until it fits in the current month. The
// weekday phase advances mod 7 with every subtracted length and folds in the
// leftover days when the result is assembled.
//
// Operation "to day number": the date is checked first (year over 99, month 0
// or over 12, day 0 or past the end of the month); an illegal date skips the
// walk and reports invalid with a zero day number. Otherwise the unit adds
// year lengths up to the given year, month lengths up to the given month and
// finally day-1.
//
// Leap years come from running mod-100 and mod-400 counters next to the year
// counter, so no divider is needed.
module calendar_day_number_converter_core import cdnc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cdnc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cdnc_out_t out_data
);

  cdnc_ctrl_t ctrl;
  cdnc_stat_t stat;

  // Sequencer: owns the handshake and drives the shared unit.
  cdnc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Datapath: accumulator, operand select, counters and result register.
  cdnc_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .ctrl     (ctrl),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

>>> design/cdnc_year_cnt.sv
// ----------------------------------------------------------------------------
// Year walker
// Year offset counter with running mod-100 and mod-400 phases for leap tests.
// ----------------------------------------------------------------------------
module cdnc_year_cnt import cdnc_pkg::*; (
  input  logic              clk,
  input  logic              clr,
  input  logic              inc,
  output logic [YCNT_W-1:0] year,
  output logic              leap
);

  logic [YCNT_W-1:0] year_r, year_nxt;
  logic [6:0]        c100_r, c100_nxt;
  logic [8:0]        c400_r, c400_nxt;

  always_comb begin
    year_nxt = year_r;
    c100_nxt = c100_r;
    c400_nxt = c400_r;
    if (clr) begin
      year_nxt = '0;
      c100_nxt = '0;
      c400_nxt = '0;
    end else if (inc) begin
      year_nxt = year_r + 9'd1;
      c100_nxt = (c100_r == CENT_LAST) ? 7'd0 : c100_r + 7'd1;
      c400_nxt = (c400_r == QUAD_CENT_LAST) ? 9'd0 : c400_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    year_r <= year_nxt;
    c100_r <= c100_nxt;
    c400_r <= c400_nxt;
  end

  assign year = year_r;
  assign leap = (year_r[1:0] == 2'b00) && ((c100_r != 7'd0) || (c400_r == 9'd0));

endmodule

>>> design/cdnc_datapath.sv
// ----------------------------------------------------------------------------
// Converter datapath
// Shared add/subtract-compare unit, operand select, walk counters, result reg.
// ----------------------------------------------------------------------------
module cdnc_datapath import cdnc_pkg::*; (
  input  logic       clk,
  input  cdnc_in_t   in_data,
  input  cdnc_ctrl_t ctrl,
  output cdnc_stat_t stat,
  output cdnc_out_t  out_data
);

  cdnc_op_t           op_r;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [BYTE_W-1:0]  y_in_r, m_in_r, d_in_r;
  logic [MONTH_W-1:0] mon_r, mon_nxt;
  logic [WDAY_W-1:0]  wd_r, wd_nxt;
  logic               bad_r;
  cdnc_out_t          out_r, out_nxt;

  logic [YCNT_W-1:0]  year;
  logic               leap;
  logic [DAY_W-1:0]   ml;
  logic [OPD_W-1:0]   opd;
  logic [ACC_W-1:0]   opd_ext;
  logic [ACC_W-1:0]   unit_res;
  logic [WDAY_W-1:0]  wd_inc;
  logic [3:0]         wd_sum;
  logic [WDAY_W-1:0]  wd_step;
  logic               leap_in;
  logic [DAY_W-1:0]   ml_in;
  logic               bad;
  logic [WDAY_W-1:0]  wd_fold;

  cdnc_year_cnt u_year (
    .clk  (clk),
    .clr  (ctrl.load),
    .inc  (ctrl.yr_inc),
    .year (year),
    .leap (leap)
  );

  assign ml = month_len(leap, mon_r);

  always_comb begin
    case (ctrl.sel)
      OPD_YEAR:  opd = leap ? LEN_LEAP_YEAR : LEN_YEAR;
      OPD_MONTH: opd = {4'b0, ml};
      OPD_DAY:   opd = {1'b0, d_in_r - 8'd1};
      default:   opd = '0;
    endcase
  end

  // Shared unit: add when building a day number, subtract when splitting one.
  assign opd_ext  = {8'b0, opd};
  assign unit_res = (op_r == OP_TO_DAYNUM) ? acc_r + opd_ext : acc_r - opd_ext;

  always_comb begin
    case (ctrl.sel)
      OPD_YEAR:  wd_inc = leap ? 3'd2 : 3'd1;
      OPD_MONTH: wd_inc = 3'(ml - 5'd28);
      default:   wd_inc = 3'd0;
    endcase
  end

  assign wd_sum  = {1'b0, wd_r} + {1'b0, wd_inc};
  assign wd_step = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[WDAY_W-1:0];

  // Offsets 0..99 sit in a century that is a multiple of 400.
  assign leap_in = (y_in_r[1:0] == 2'b00);
  assign ml_in   = month_len(leap_in, m_in_r[MONTH_W-1:0]);
  assign bad     = (y_in_r > YEAR_LAST) || (m_in_r == 8'd0) || (m_in_r > MONTH_LAST_IN) ||
                   (d_in_r == 8'd0) || (d_in_r > {3'b0, ml_in});

  assign stat.op       = op_r;
  assign stat.less     = (acc_r < opd_ext);
  assign stat.year_hit = (year == {1'b0, y_in_r});
  assign stat.mon_hit  = (mon_r == m_in_r[MONTH_W-1:0]);
  assign stat.mon_last = (mon_r == MONTH_LAST);
  assign stat.bad      = bad;

  always_comb begin
    acc_nxt = acc_r;
    mon_nxt = mon_r;
    wd_nxt  = wd_r;
    if (ctrl.load) begin
      acc_nxt = (in_data.operation == OP_TO_DAYNUM) ? '0 : in_data.day_number_in;
      mon_nxt = MONTH_FIRST;
      wd_nxt  = WDAY_DAY0;
    end else if (ctrl.acc_en) begin
      acc_nxt = unit_res;
      if (op_r == OP_TO_DATE) wd_nxt = wd_step;
      if (ctrl.mon_inc) mon_nxt = mon_r + 4'd1;
    end
  end

  assign wd_fold = mod7_small({3'b0, wd_r} + {1'b0, acc_r[DAY_W-1:0]});

  always_comb begin
    out_nxt = '0;
    if (op_r == OP_TO_DATE) begin
      out_nxt.year_out    = year[BYTE_W-1:0];
      out_nxt.month_out   = mon_r;
      out_nxt.day_out     = acc_r[DAY_W-1:0] + 5'd1;
      out_nxt.weekday_out = (wd_fold == 3'd0) ? WDAY_SUNDAY : wd_fold;
    end else begin
      out_nxt.invalid        = bad_r;
      out_nxt.day_number_out = bad_r ? '0 : acc_r[DAYNUM_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mon_r <= mon_nxt;
    wd_r  <= wd_nxt;
    if (ctrl.load) begin
      op_r   <= in_data.operation;
      y_in_r <= in_data.year_in;
      m_in_r <= in_data.month_in;
      d_in_r <= in_data.day_in;
      bad_r  <= 1'b0;
    end else if (ctrl.bad_set) begin
      bad_r  <= bad;
    end
    if (ctrl.out_load) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

>>> design/cdnc_seq.sv
// ----------------------------------------------------------------------------
// Converter sequencer
// Steps the shared unit through check, year, month and day phases.
// ----------------------------------------------------------------------------
module cdnc_seq import cdnc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  cdnc_stat_t stat,
  output cdnc_ctrl_t ctrl
);

  cdnc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_busy;
  logic        to_date;

  assign out_busy = out_valid_r && out_stall;
  assign to_date  = (stat.op == OP_TO_DATE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (to_date) state_nxt = ST_YEAR;
        else if (stat.bad) state_nxt = ST_FINISH;
        else state_nxt = ST_YEAR;
      end
      ST_YEAR: begin
        if (to_date ? stat.less : stat.year_hit) state_nxt = ST_MONTH;
      end
      ST_MONTH: begin
        if (to_date) begin
          if (stat.less || stat.mon_last) state_nxt = ST_FINISH;
        end else if (stat.mon_hit) begin
          state_nxt = ST_DAY;
        end
      end
      ST_DAY: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.sel = OPD_YEAR;
    case (state_r)
      ST_IDLE: begin
        ctrl.load = in_valid;
      end
      ST_CHECK: begin
        ctrl.bad_set = !to_date;
      end
      ST_YEAR: begin
        if (to_date ? !stat.less : !stat.year_hit) begin
          ctrl.acc_en = 1'b1;
          ctrl.yr_inc = 1'b1;
        end
      end
      ST_MONTH: begin
        ctrl.sel = OPD_MONTH;
        if (to_date ? !(stat.less || stat.mon_last) : !stat.mon_hit) begin
          ctrl.acc_en  = 1'b1;
          ctrl.mon_inc = 1'b1;
        end
      end
      ST_DAY: begin
        ctrl.sel    = OPD_DAY;
        ctrl.acc_en = 1'b1;
      end
      ST_FINISH: begin
        ctrl.out_load = !out_busy;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> design/cdnc_checker.sv
// ----------------------------------------------------------------------------
// Converter port checker
// Watches the core's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "calendar_day_number_converter_core_defines.svh"

module cdnc_checker import cdnc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input cdnc_out_t out_data
);

  logic out_hold;
  logic in_take;
  logic out_bad;
  logic bad_clean;

  assign out_hold  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign out_bad   = out_valid && out_data.invalid;
  assign bad_clean = (out_data.day_number_out == '0) && (out_data.month_out == '0);

  // Hold a stalled result beat.
  `CDNC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_valid, "stalled beat dropped")
  `CDNC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_hold, $stable(out_data), "stalled beat changed")
  // A taken beat keeps the input side busy next cycle.
  `CDNC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, in_stall, "idle after take")
  // An invalid date carries a zero day number and a zero month field.
  `CDNC_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_bad, bad_clean, "invalid beat carries data")

endmodule

bind calendar_day_number_converter_core cdnc_checker u_cdnc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/tb_calendar_day_number_converter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar day number converter core testbench
// Drives day-number-to-date and date-to-day-number beats through the core
// with random gaps and output stalls. Every result is compared field by field
// against a behavioral calendar model, or against values typed into the
// directed table for the easy corner cases.
// ----------------------------------------------------------------------------
module tb_calendar_day_number_converter_core;
  import cdnc_pkg::*;

  localparam int CLK_HALF_NS   = 5;
  localparam int TIMEOUT_NS    = 30_000_000;
  localparam int RANDOM_BEATS  = 1300;
  localparam int HOLD_CYCLES   = 500;  // long receiver hold-off
  localparam int DRAIN_CYCLES  = 400;  // covers the slowest date split
  localparam int DAYNUM_LAST   = 93501;
  localparam int DAYNUM_MAX    = 131071;

  // One directed row: the beat, whether the result is typed in, and that result.
  typedef struct {
    cdnc_in_t  beat;
    bit        typed;
    cdnc_out_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  cdnc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  cdnc_out_t out_data;

  cdnc_out_t pending_results[$];  // expected results, oldest first
  int        error_count = 0;
  bit        calm = 1'b0;          // no gaps and no stalls while set
  bit        hold_off_req = 1'b0;  // asks the receiver for one long hold-off

  calendar_day_number_converter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // --------------------------------------------------------------------------
  // Calendar model
  // --------------------------------------------------------------------------
  // Offsets from 2000, and 2000 is a multiple of 400, so the Gregorian rules
  // apply to the offset directly.
  function automatic bit leap_year(int unsigned y);
    return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
  endfunction

  function automatic int unsigned year_days(int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  // m must be 1..12
  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic cdnc_out_t predict_conversion(cdnc_in_t b);
    cdnc_out_t   r;
    int unsigned d;
    int unsigned y;
    int unsigned m;
    int unsigned wd;
    int unsigned n;
    r = '0;
    if (b.operation == OP_TO_DATE) begin
      d  = b.day_number_in;
      wd = (d + WDAY_DAY0) % 7;
      if (wd == 0) wd = WDAY_SUNDAY;
      // Peel whole years, then whole months; December absorbs the rest.
      y = 0;
      while (d >= year_days(y)) begin
        d -= year_days(y);
        y++;
      end
      m = 1;
      while (m != MONTH_LAST && d >= month_days(y, m)) begin
        d -= month_days(y, m);
        m++;
      end
      r.year_out    = 8'(y);  // wraps past offset 255
      r.month_out   = 4'(m);
      r.day_out     = 5'(d + 1);
      r.weekday_out = 3'(wd);
    end else begin
      y = b.year_in;
      m = b.month_in;
      d = b.day_in;
      if (y > YEAR_LAST || m == 0 || m > MONTH_LAST_IN || d == 0 || d > month_days(y, m)) begin
        r.invalid = 1'b1;
      end else begin
        n = d - 1;
        for (int unsigned k = 0; k < y; k++) n += year_days(k);
        for (int unsigned k = 1; k < m; k++) n += month_days(y, k);
        r.day_number_out = 16'(n);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Beat and result builders
  // --------------------------------------------------------------------------
  function automatic cdnc_in_t to_date_beat(int unsigned dn);
    cdnc_in_t b;
    b = '0;
    b.operation     = OP_TO_DATE;
    b.day_number_in = 17'(dn);
    return b;
  endfunction

  function automatic cdnc_in_t to_daynum_beat(int unsigned y, int unsigned m, int unsigned d);
    cdnc_in_t b;
    b = '0;
    b.operation = OP_TO_DAYNUM;
    b.year_in   = 8'(y);
    b.month_in  = 8'(m);
    b.day_in    = 8'(d);
    return b;
  endfunction

  function automatic cdnc_out_t date_res(int unsigned y, int unsigned m, int unsigned d,
                                         int unsigned wd);
    cdnc_out_t r;
    r = '0;
    r.year_out    = 8'(y);
    r.month_out   = 4'(m);
    r.day_out     = 5'(d);
    r.weekday_out = 3'(wd);
    return r;
  endfunction

  function automatic cdnc_out_t daynum_res(int unsigned n);
    cdnc_out_t r;
    r = '0;
    r.day_number_out = 16'(n);
    return r;
  endfunction

  function automatic cdnc_out_t bad_date_res();
    cdnc_out_t r;
    r = '0;
    r.invalid = 1'b1;
    return r;
  endfunction

  // Mostly well-formed dates with random content; the rest are broken dates
  // and day numbers past the end of 2255. Unused fields carry random noise.
  function automatic cdnc_in_t random_beat();
    cdnc_in_t    b;
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    b.day_number_in = 17'($urandom);
    b.year_in       = 8'($urandom);
    b.month_in      = 8'($urandom);
    b.day_in        = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      b.operation = OP_TO_DATE;
      if (pick < 8)       b.day_number_in = 17'($urandom_range(0, 800));
      else if (pick < 38) b.day_number_in = 17'($urandom_range(0, DAYNUM_LAST));
      else                b.day_number_in = 17'($urandom_range(DAYNUM_LAST + 1, DAYNUM_MAX));
    end else begin
      b.operation = OP_TO_DAYNUM;
      y = $urandom_range(0, YEAR_LAST);
      m = $urandom_range(1, MONTH_LAST_IN);
      b.year_in  = 8'(y);
      b.month_in = 8'(m);
      b.day_in   = 8'($urandom_range(1, month_days(y, m)));
      if (pick >= 82) begin
        // Break one rule of the date.
        case (pick % 6)
          0:       b.year_in  = 8'($urandom_range(YEAR_LAST + 1, 255));
          1:       b.month_in = '0;
          2:       b.month_in = 8'($urandom_range(MONTH_LAST_IN + 1, 255));
          3:       b.day_in   = '0;
          4:       b.day_in   = 8'(month_days(y, m) + 1);
          default: begin
            b.year_in  = 8'($urandom);
            b.month_in = 8'($urandom);
            b.day_in   = 8'($urandom);
          end
        endcase
      end
    end
    return b;
  endfunction

  // Mostly short idle runs, a few long ones, none while calm.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85)         return $urandom_range(1, 3);
    if (r < 97)         return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offer one beat and hold it until taken; queue its result on acceptance.
  // in_valid stays high across back-to-back beats.
  task automatic send_beat(cdnc_in_t b, cdnc_out_t want);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(want);
  endtask

  task automatic wait_all_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    dir_row_t   directed_rows[$];
    cdnc_in_t   b;
    cdnc_in_t   noisy;

    // Reset is held low from time zero, then released.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Day number to date: first day, last in-range day, leap day, weekday wrap.
    directed_rows.push_back('{to_date_beat(0), 1'b1, date_res(0, 1, 1, 6)});
    directed_rows.push_back('{to_date_beat(1), 1'b1, date_res(0, 1, 2, 7)});
    directed_rows.push_back('{to_date_beat(59), 1'b1, date_res(0, 2, 29, 2)});
    directed_rows.push_back('{to_date_beat(36524), 1'b1, date_res(99, 12, 31, 4)});
    directed_rows.push_back('{to_date_beat(DAYNUM_LAST), 1'b1, date_res(255, 12, 31, 1)});
    // 2100 is not a leap year: the day after 28 Feb is 1 Mar.
    directed_rows.push_back('{to_date_beat(36583), 1'b0, '0});
    directed_rows.push_back('{to_date_beat(36584), 1'b0, '0});
    // Day 65536, and days past 2255, where the year offset wraps.
    directed_rows.push_back('{to_date_beat(DAYNUM_LAST + 1), 1'b0, '0});
    directed_rows.push_back('{to_date_beat(65536), 1'b0, '0});
    directed_rows.push_back('{to_date_beat(DAYNUM_MAX), 1'b0, '0});
    // Date to day number: extremes and leap day.
    directed_rows.push_back('{to_daynum_beat(0, 1, 1), 1'b1, daynum_res(0)});
    directed_rows.push_back('{to_daynum_beat(0, 2, 29), 1'b1, daynum_res(59)});
    directed_rows.push_back('{to_daynum_beat(99, 12, 31), 1'b1, daynum_res(36524)});
    directed_rows.push_back('{to_daynum_beat(4, 2, 29), 1'b0, '0});
    directed_rows.push_back('{to_daynum_beat(5, 4, 30), 1'b0, '0});
    // Illegal dates: year, month zero, month high, day zero, past month end.
    directed_rows.push_back('{to_daynum_beat(100, 1, 1), 1'b1, bad_date_res()});
    directed_rows.push_back('{to_daynum_beat(255, 255, 255), 1'b1, bad_date_res()});
    directed_rows.push_back('{to_daynum_beat(5, 0, 10), 1'b1, bad_date_res()});
    directed_rows.push_back('{to_daynum_beat(5, 13, 1), 1'b1, bad_date_res()});
    directed_rows.push_back('{to_daynum_beat(5, 3, 0), 1'b1, bad_date_res()});
    directed_rows.push_back('{to_daynum_beat(5, 4, 31), 1'b1, bad_date_res()});
    directed_rows.push_back('{to_daynum_beat(1, 2, 29), 1'b1, bad_date_res()});
    directed_rows.push_back('{to_daynum_beat(7, 1, 32), 1'b1, bad_date_res()});
    // Unused fields at all ones must not leak into the result.
    noisy = to_date_beat(12345);
    noisy.year_in  = '1;
    noisy.month_in = '1;
    noisy.day_in   = '1;
    directed_rows.push_back('{noisy, 1'b0, '0});
    noisy = to_daynum_beat(50, 6, 15);
    noisy.day_number_in = '1;
    directed_rows.push_back('{noisy, 1'b0, '0});

    foreach (directed_rows[i]) begin
      b = directed_rows[i].beat;
      send_beat(b, directed_rows[i].typed ? directed_rows[i].want : predict_conversion(b));
    end

    // Pause the sender until the core has drained.
    in_valid <= 1'b0;
    wait_all_results();
    @(posedge clk);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // Alternate stretches with and without idling.
      calm = ((i / 100) % 4) == 1;
      // Hold off the receiver while beats keep coming, so the core backs up.
      if (i == 300) hold_off_req = 1'b1;
      if (i == 700) begin
        in_valid <= 1'b0;
        wait_all_results();
        @(posedge clk);
      end
      b = random_beat();
      send_beat(b, predict_conversion(b));
    end

    in_valid <= 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_calendar_day_number_converter_core passed");
    end else begin
      $display("tb_calendar_day_number_converter_core failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver stall
  // --------------------------------------------------------------------------
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = idle_len();
        if (n == 0) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------
  task automatic compare_field(string name, int unsigned want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      error_count++;
    end
  endtask

  // Sample at the edge: values seen here are those the core saw.
  always @(posedge clk) begin
    cdnc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $realtime, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("day_number_out", want.day_number_out, 32'(out_data.day_number_out));
        compare_field("invalid", want.invalid, 32'(out_data.invalid));
        compare_field("year_out", want.year_out, 32'(out_data.year_out));
        compare_field("month_out", want.month_out, 32'(out_data.month_out));
        compare_field("day_out", want.day_out, 32'(out_data.day_out));
        compare_field("weekday_out", want.weekday_out, 32'(out_data.weekday_out));
      end
    end
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_calendar_day_number_converter_core failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/cdnc_pkg.sv
design/cdnc_year_cnt.sv
design/cdnc_datapath.sv
design/cdnc_seq.sv
design/calendar_day_number_converter_core.sv
design/cdnc_checker.sv
tb/tb_calendar_day_number_converter_core.sv
